### src/control_frame_deframer_defines.svh
// Assertion macros for the control frame deframer.
// Used by control_frame_deframer.sv; expects clk and rst in scope.
`ifndef CONTROL_FRAME_DEFRAMER_DEFINES_SVH
`define CONTROL_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/cfd_pkg.sv
// Shared types and constants for the control frame deframer.
// No dependencies; imported by control_frame_deframer and tb.
package cfd_pkg;

  // Frame parser phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EXT  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  // Classification of one received byte
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_EXT_LEN = 3'd1,
    KIND_FIELD   = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_DATA    = 3'd4,
    KIND_DROP    = 3'd5
  } kind_t;

  // Frame status reported on the last byte
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_t;

  // Opcodes
  localparam logic [2:0] OP_OPEN   = 3'h1;
  localparam logic [2:0] OP_CLOSE  = 3'h3;
  localparam logic [2:0] OP_STREAM = 3'h5;

  // Header length code that announces a 4-byte length
  localparam logic [4:0] LEN_EXTENDED = 5'd31;

  // Reset value of the frame size limit
  localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

endpackage

### src/control_frame_deframer.sv
// Control frame deframer: classifies each received byte, decodes frame fields.
// One parse step lies between input port and result register, loaded on accept.
// Throughput: one byte per cycle unless the output stalls (out_valid && !out_ready).
// Reset (rst, synchronous): parser idle awaiting a header, limit set to 4096.
// Depends on cfd_pkg and control_frame_deframer_defines.svh.
`include "control_frame_deframer_defines.svh"

module control_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_kind,
  output logic [2:0]  opcode,
  output logic [31:0] frame_len,
  output logic [31:0] offset,
  output logic [7:0]  data_out,
  output logic [31:0] baud_rate,
  output logic [15:0] name_len,
  output logic [31:0] trans_id,
  output logic        frame_end,
  output logic [2:0]  status
);
  import cfd_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [2:0]  cur_opcode, cur_opcode_next;
  logic [31:0] len_reg, len_reg_next;
  logic [1:0]  ext_count, ext_count_next;
  logic [31:0] recv_count, recv_count_next;
  logic [31:0] baud_reg, baud_reg_next;
  logic [15:0] namelen_reg, namelen_reg_next;
  logic [31:0] txid_reg, txid_reg_next;
  logic [31:0] max_frame_len;

  // Per-byte result
  kind_t       kind;
  logic [31:0] fl;
  logic [31:0] off;
  logic        fend;
  status_t     st;

  // Payload decode helpers
  logic [32:0] off_w;
  logic [32:0] nl_p2;
  logic [32:0] nl_p6;
  logic        oversize;
  logic [32:0] need_len;
  logic [31:0] min_len;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign off_w    = {1'b0, recv_count};
  assign nl_p2    = {17'b0, namelen_reg} + 33'd2;
  assign nl_p6    = {17'b0, namelen_reg} + 33'd6;
  assign oversize = len_reg > max_frame_len;

  // Parse one byte: next state and classification
  always_comb begin
    phase_next       = phase;
    cur_opcode_next  = cur_opcode;
    len_reg_next     = len_reg;
    ext_count_next   = ext_count;
    recv_count_next  = recv_count;
    baud_reg_next    = baud_reg;
    namelen_reg_next = namelen_reg;
    txid_reg_next    = txid_reg;
    kind             = KIND_HEADER;
    fl               = '0;
    off              = '0;
    fend             = 1'b0;

    case (phase)
      PH_EXT: begin
        kind         = KIND_EXT_LEN;
        len_reg_next = {len_reg[23:0], rx_byte};
        if (ext_count == 2'd3) begin
          ext_count_next = '0;
          fl             = len_reg_next;
          if (len_reg_next == '0) fend = 1'b1;
          else phase_next = PH_PAY;
        end else begin
          ext_count_next = ext_count + 2'd1;
        end
      end
      PH_PAY: begin
        off             = recv_count;
        fl              = len_reg;
        recv_count_next = recv_count + 32'd1;
        if (recv_count_next >= len_reg) fend = 1'b1;
        if (oversize) begin
          kind = KIND_DROP;
        end else begin
          case (cur_opcode)
            OP_OPEN: begin
              if (off_w < 33'd4) begin
                baud_reg_next = {baud_reg[23:0], rx_byte};
                kind          = KIND_FIELD;
              end else if (off_w < 33'd6) begin
                namelen_reg_next = {namelen_reg[7:0], rx_byte};
                kind             = KIND_FIELD;
              end else if (off_w < nl_p6) begin
                kind = KIND_NAME;
              end else begin
                kind = KIND_DROP;
              end
            end
            OP_CLOSE: begin
              if (off_w < 33'd2) begin
                namelen_reg_next = {namelen_reg[7:0], rx_byte};
                kind             = KIND_FIELD;
              end else if (off_w < nl_p2) begin
                kind = KIND_NAME;
              end else begin
                kind = KIND_DROP;
              end
            end
            OP_STREAM: begin
              if (off_w < 33'd2) begin
                namelen_reg_next = {namelen_reg[7:0], rx_byte};
                kind             = KIND_FIELD;
              end else if (off_w < nl_p2) begin
                kind = KIND_NAME;
              end else if (off_w < nl_p6) begin
                txid_reg_next = {txid_reg[23:0], rx_byte};
                kind          = KIND_FIELD;
              end else begin
                kind = KIND_DATA;
              end
            end
            default: kind = KIND_DROP;
          endcase
        end
      end
      default: begin
        // header byte: start a new frame
        kind             = KIND_HEADER;
        cur_opcode_next  = rx_byte[2:0];
        recv_count_next  = '0;
        baud_reg_next    = '0;
        namelen_reg_next = '0;
        txid_reg_next    = '0;
        ext_count_next   = '0;
        if (rx_byte[7:3] == LEN_EXTENDED) begin
          len_reg_next = '0;
          phase_next   = PH_EXT;
        end else begin
          len_reg_next = {27'b0, rx_byte[7:3]};
          fl           = len_reg_next;
          if (rx_byte[7:3] == 5'd0) fend = 1'b1;
          else phase_next = PH_PAY;
        end
      end
    endcase

    if (fend) phase_next = PH_IDLE;
  end

  // Frame status from the updated length and name length
  always_comb begin
    min_len  = (cur_opcode_next == OP_CLOSE) ? 32'd2 : 32'd6;
    need_len = {17'b0, namelen_reg_next} +
               ((cur_opcode_next == OP_CLOSE) ? 33'd2 : 33'd6);
    st = ST_OK;
    if (fend) begin
      if (len_reg_next > max_frame_len) begin
        st = ST_OVERSIZE;
      end else if (cur_opcode_next != OP_OPEN && cur_opcode_next != OP_CLOSE &&
                   cur_opcode_next != OP_STREAM) begin
        st = ST_UNKNOWN;
      end else if (len_reg_next < min_len) begin
        st = ST_SHORT;
      end else if (need_len > {1'b0, len_reg_next}) begin
        st = ST_OVERRUN;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_frame_len <= cfg_wdata;
    end
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cur_opcode  <= '0;
      len_reg     <= '0;
      ext_count   <= '0;
      recv_count  <= '0;
      baud_reg    <= '0;
      namelen_reg <= '0;
      txid_reg    <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      cur_opcode  <= cur_opcode_next;
      len_reg     <= len_reg_next;
      ext_count   <= ext_count_next;
      recv_count  <= recv_count_next;
      baud_reg    <= baud_reg_next;
      namelen_reg <= namelen_reg_next;
      txid_reg    <= txid_reg_next;
    end
  end

  // Output valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_kind <= kind;
      opcode    <= cur_opcode_next;
      frame_len <= fl;
      offset    <= off;
      data_out  <= rx_byte;
      baud_rate <= baud_reg_next;
      name_len  <= namelen_reg_next;
      trans_id  <= txid_reg_next;
      frame_end <= fend;
      status    <= st;
    end
  end

  `CFD_ASSERT_IMP(a_pay_len_nonzero, phase == PH_PAY, len_reg != 32'd0, "payload phase with zero length")
  `CFD_ASSERT_IMP(a_ext_count_phase, ext_count != 2'd0, phase == PH_EXT, "extended length count outside length phase")
  `CFD_ASSERT_IMP(a_status_at_end, out_valid && !frame_end, status == ST_OK, "status reported before frame end")
  `CFD_ASSERT_NXT(a_last_byte_idle, accept && phase == PH_PAY && (recv_count + 32'd1) >= len_reg, phase == PH_IDLE, "parser not idle after last payload byte")

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for control_frame_deframer: feeds control frames byte by byte
// through the valid/ready request channels and checks each byte classification in order.
// Depends on cfd_pkg and the control_frame_deframer RTL.
module tb;
  import cfd_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 275;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 200;

  // Header forms for queue_frame
  localparam int HDR_SHORT  = 0;
  localparam int HDR_EXT    = 1;
  localparam int HDR_EITHER = 2;

  // Opcodes without a decoder
  localparam logic [2:0] OP_UNUSED_LO = 3'd0;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Expected classification of one byte
  typedef struct {
    kind_t       kind;
    logic [2:0]  op;
    logic [31:0] flen;
    logic [31:0] offs;
    logic [7:0]  data;
    logic [31:0] baud;
    logic [15:0] nlen;
    logic [31:0] txid;
    logic        fend;
    status_t     stat;
  } byte_class_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  byte_kind;
  logic [2:0]  opcode;
  logic [31:0] frame_len;
  logic [31:0] offset;
  logic [7:0]  data_out;
  logic [31:0] baud_rate;
  logic [15:0] name_len;
  logic [31:0] trans_id;
  logic        frame_end;
  logic [2:0]  status;

  // Parser state mirrored by the predictor
  phase_t      prs_phase;
  logic [2:0]  prs_op;
  logic [31:0] prs_len;
  logic [1:0]  prs_ext_cnt;
  logic [31:0] prs_count;
  logic [31:0] prs_baud;
  logic [15:0] prs_namelen;
  logic [31:0] prs_txid;
  logic [31:0] prs_limit;

  logic [7:0]  byte_backlog[$];
  logic [7:0]  frame_body[$];
  byte_class_t class_expected[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int errors = 0;
  int bytes_queued = 0;
  int bytes_checked = 0;
  int frames_checked = 0;
  int limits_written = 0;
  int status_count[5] = '{0, 0, 0, 0, 0};

  control_frame_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_kind (byte_kind),
    .opcode    (opcode),
    .frame_len (frame_len),
    .offset    (offset),
    .data_out  (data_out),
    .baud_rate (baud_rate),
    .name_len  (name_len),
    .trans_id  (trans_id),
    .frame_end (frame_end),
    .status    (status)
  );

  always #(CLK_HALF) clk = ~clk;

  // Advance the parser by one byte and return its classification
  function automatic byte_class_t classify_byte(input logic [7:0] b);
    byte_class_t r;
    longint unsigned len;
    longint unsigned nl;
    longint unsigned off;
    logic done;
    r.kind = KIND_HEADER;
    r.flen = '0;
    r.offs = '0;
    r.data = b;
    r.stat = ST_OK;
    done = 1'b0;
    case (prs_phase)
      PH_EXT: begin
        r.kind = KIND_EXT_LEN;
        prs_len = {prs_len[23:0], b};
        if (prs_ext_cnt == 2'd3) begin
          prs_ext_cnt = '0;
          r.flen = prs_len;
          if (prs_len == 0) done = 1'b1;
          else prs_phase = PH_PAY;
        end else begin
          prs_ext_cnt = prs_ext_cnt + 2'd1;
        end
      end
      PH_PAY: begin
        r.offs = prs_count;
        r.flen = prs_len;
        off = prs_count;
        nl = prs_namelen;
        if (prs_len > prs_limit) begin
          r.kind = KIND_DROP;
        end else if (prs_op == OP_OPEN) begin
          if (off < 4) begin
            prs_baud = {prs_baud[23:0], b};
            r.kind = KIND_FIELD;
          end else if (off < 6) begin
            prs_namelen = {prs_namelen[7:0], b};
            r.kind = KIND_FIELD;
          end else if (off < 6 + nl) begin
            r.kind = KIND_NAME;
          end else begin
            r.kind = KIND_DROP;
          end
        end else if (prs_op == OP_CLOSE) begin
          if (off < 2) begin
            prs_namelen = {prs_namelen[7:0], b};
            r.kind = KIND_FIELD;
          end else if (off < 2 + nl) begin
            r.kind = KIND_NAME;
          end else begin
            r.kind = KIND_DROP;
          end
        end else if (prs_op == OP_STREAM) begin
          if (off < 2) begin
            prs_namelen = {prs_namelen[7:0], b};
            r.kind = KIND_FIELD;
          end else if (off < 2 + nl) begin
            r.kind = KIND_NAME;
          end else if (off < 6 + nl) begin
            prs_txid = {prs_txid[23:0], b};
            r.kind = KIND_FIELD;
          end else begin
            r.kind = KIND_DATA;
          end
        end else begin
          r.kind = KIND_DROP;
        end
        prs_count = prs_count + 1;
        if (prs_count >= prs_len) done = 1'b1;
      end
      default: begin
        // header byte: restart all decode registers
        prs_op = b[2:0];
        prs_count = '0;
        prs_baud = '0;
        prs_namelen = '0;
        prs_txid = '0;
        prs_ext_cnt = '0;
        if (b[7:3] == LEN_EXTENDED) begin
          prs_len = '0;
          prs_phase = PH_EXT;
        end else begin
          prs_len = {27'd0, b[7:3]};
          r.flen = prs_len;
          if (prs_len == 0) done = 1'b1;
          else prs_phase = PH_PAY;
        end
      end
    endcase
    // report status on the last byte, oversize first
    if (done) begin
      len = prs_len;
      nl = prs_namelen;
      if (prs_len > prs_limit) begin
        r.stat = ST_OVERSIZE;
      end else if (prs_op == OP_OPEN || prs_op == OP_STREAM) begin
        if (len < 6) r.stat = ST_SHORT;
        else if (6 + nl > len) r.stat = ST_OVERRUN;
      end else if (prs_op == OP_CLOSE) begin
        if (len < 2) r.stat = ST_SHORT;
        else if (2 + nl > len) r.stat = ST_OVERRUN;
      end else begin
        r.stat = ST_UNKNOWN;
      end
      prs_phase = PH_IDLE;
    end
    r.fend = done;
    r.op = prs_op;
    r.baud = prs_baud;
    r.nlen = prs_namelen;
    r.txid = prs_txid;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Queue header, optional extended length and frame_body as one frame
  task automatic queue_frame(input logic [2:0] op, input int hdr_form);
    logic [31:0] len;
    len = frame_body.size();
    if (hdr_form == HDR_EXT || len > 30 ||
        (hdr_form == HDR_EITHER && $urandom_range(0, 5) == 0)) begin
      byte_backlog.push_back({LEN_EXTENDED, op});
      byte_backlog.push_back(len[31:24]);
      byte_backlog.push_back(len[23:16]);
      byte_backlog.push_back(len[15:8]);
      byte_backlog.push_back(len[7:0]);
      bytes_queued += 5;
    end else begin
      byte_backlog.push_back({len[4:0], op});
      bytes_queued++;
    end
    foreach (frame_body[i]) byte_backlog.push_back(frame_body[i]);
    bytes_queued += len;
  endtask

  // Mostly well-formed frames with random content, else unknown opcodes or garbage
  task automatic queue_random_frame();
    int unsigned sel;
    int unsigned nl;
    int unsigned n;
    logic [2:0] op;
    frame_body = {};
    sel = $urandom_range(0, 99);
    if (sel < 72) begin
      nl = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      case ($urandom_range(0, 2))
        0: begin
          op = OP_OPEN;
          repeat (4) frame_body.push_back(8'($urandom));
        end
        1: op = OP_CLOSE;
        default: op = OP_STREAM;
      endcase
      frame_body.push_back(nl[15:8]);
      frame_body.push_back(nl[7:0]);
      repeat (nl) frame_body.push_back(8'($urandom));
      if (op == OP_STREAM) begin
        repeat (4) frame_body.push_back(8'($urandom));
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 24);
      end else begin
        n = $urandom_range(0, 3);
      end
      repeat (n) frame_body.push_back(8'($urandom));
    end else if (sel < 84) begin
      do op = 3'($urandom_range(0, 7));
      while (op == OP_OPEN || op == OP_CLOSE || op == OP_STREAM);
      repeat ($urandom_range(0, 40)) frame_body.push_back(8'($urandom));
    end else begin
      // known opcode, random bytes: short frames and wild name lengths
      case ($urandom_range(0, 2))
        0: op = OP_OPEN;
        1: op = OP_CLOSE;
        default: op = OP_STREAM;
      endcase
      repeat ($urandom_range(0, 12)) frame_body.push_back(8'($urandom));
    end
    queue_frame(op, HDR_EITHER);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    prs_limit = v;
    limits_written++;
  endtask

  // Hold until every queued request is accepted and every result checked
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || class_expected.size() != 0);
  endtask

  // Request driver: offer the next byte, keep it steady until accepted
  always @(posedge clk) begin : drive_bytes
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid;
    next_byte = rx_byte;
    if (in_valid && in_ready) begin
      class_expected.push_back(classify_byte(rx_byte));
      next_valid = 1'b0;
    end
    if (!next_valid && !rst && byte_backlog.size() != 0 &&
        $urandom_range(0, 99) >= sender_idle_pct) begin
      next_byte = byte_backlog.pop_front();
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
    rx_byte <= next_byte;
  end

  // Result monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_bytes
    byte_class_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (class_expected.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual kind %0d data %0h",
                   $time, byte_kind, data_out);
        errors++;
      end else begin
        want = class_expected.pop_front();
        check_field("byte_kind", want.kind, byte_kind);
        check_field("opcode", want.op, opcode);
        check_field("frame_len", want.flen, frame_len);
        check_field("offset", want.offs, offset);
        check_field("data_out", want.data, data_out);
        check_field("baud_rate", want.baud, baud_rate);
        check_field("name_len", want.nlen, name_len);
        check_field("trans_id", want.txid, trans_id);
        check_field("frame_end", want.fend, frame_end);
        check_field("status", want.stat, status);
        bytes_checked++;
        if (want.fend) begin
          frames_checked++;
          status_count[int'(want.stat)]++;
        end
      end
    end
    out_ready <= !rst && hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, class_expected.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0] limit_plan[NUM_PHASES];
    int sender_plan[NUM_PHASES];
    int stall_plan[NUM_PHASES];
    int quota;
    int midway;
    limit_plan = '{MAX_LEN_RESET, 32'hFFFF_FFFF, 32'd0, 32'd20, 32'd300, 32'd12};
    sender_plan = '{0, 71, 0, 26, 0, 26};
    stall_plan = '{0, 0, 71, 26, 0, 26};
    prs_phase = PH_IDLE;
    prs_op = '0;
    prs_len = '0;
    prs_ext_cnt = '0;
    prs_count = '0;
    prs_baud = '0;
    prs_namelen = '0;
    prs_txid = '0;
    prs_limit = MAX_LEN_RESET;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero-length frames in both header forms, one of each opcode,
    // widest name length, then an oversize frame under a zero limit
    frame_body = {};
    queue_frame(OP_UNUSED_LO, HDR_SHORT);
    queue_frame(OP_OPEN, HDR_EXT);
    frame_body = {8'h00, 8'h01, 8'h41};
    queue_frame(OP_CLOSE, HDR_SHORT);
    frame_body = {8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h5A};
    queue_frame(OP_STREAM, HDR_SHORT);
    frame_body = {8'h00, 8'h01, 8'hC2, 8'h00, 8'hFF, 8'hFF};
    queue_frame(OP_OPEN, HDR_SHORT);
    frame_body = {8'hFF, 8'h80};
    queue_frame(OP_UNUSED_HI, HDR_SHORT);
    wait_drained();
    write_limit(32'd0);
    frame_body = {8'h7E};
    queue_frame(OP_CLOSE, HDR_SHORT);
    wait_drained();

    // Random phases, each under its own limit and idle pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(limit_plan[ph]);
      sender_idle_pct = sender_plan[ph];
      recv_stall_pct = stall_plan[ph];
      quota = bytes_queued + PHASE_BYTES;
      midway = bytes_queued + PHASE_BYTES / 2;
      while (bytes_queued < quota) begin
        queue_random_frame();
        // pause the sender until all results are back
        if (ph == 4 && midway != 0 && bytes_queued >= midway) begin
          midway = 0;
          wait_drained();
        end
      end
      // stall the receiver while the backlog keeps pushing requests
      if (ph == 3) begin
        @(negedge clk);
        hold_req = 1'b1;
      end
      wait_drained();
    end
    repeat (4) @(posedge clk);

    $display("Checked %0d bytes in %0d frames under %0d limit settings", bytes_checked,
             frames_checked, limits_written);
    $display("Frame status: ok %0d, unknown %0d, short %0d, overrun %0d, oversize %0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
